@@ rtl/cbpp_pkg.sv @@
// ============================================================================
// cbpp_pkg: shared definitions for the buffer pool slot table
// Operation and status codes, field widths and the reset value of slots_in_use.
// ============================================================================
package cbpp_pkg;

    localparam int NUM_SLOTS_DEF     = 16;
    localparam int CHUNK_ID_BITS_DEF = 16;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 5;
    localparam int SLOT_IDX_W = 4;

    localparam logic [OP_W-1:0] OP_PIN      = 3'd0;
    localparam logic [OP_W-1:0] OP_PIN_AT   = 3'd1;
    localparam logic [OP_W-1:0] OP_UNPIN    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD     = 3'd3;
    localparam logic [OP_W-1:0] OP_DIRTY    = 3'd4;
    localparam logic [OP_W-1:0] OP_FLUSH    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PINNED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTRES = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTPIN = 3'd4;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

@@ rtl/chunk_buffer_pool_pin_policy_unit.sv @@
// ============================================================================
// chunk_buffer_pool_pin_policy_unit: buffer pool slot table
// Pin, unpin, load, dirty and flush bookkeeping with round-robin replacement.
// ============================================================================
// Usage. A request (operation, chunk_id, slot_index) is taken on the input
// channel when in_valid is high and in_stall is low; exactly one result
// (status, slot, must_read, must_write, write_chunk_id) follows on the output
// channel, held steady while out_stall is high. One request is worked on at a
// time. The slot tags live in a synchronous memory with a registered read
// port; the lookup walks the active slots one per cycle, reading the tag
// memory, and a pin that misses then walks round-robin from the slot after
// the last pinned one, again one slot per cycle. The output register frees
// the engine once a result is written to it, and the next request can be
// taken once the engine has gone on through S_DONE back to S_IDLE, even while
// that result waits; the engine then holds its next result until the
// register empties, and in_stall stays high meanwhile.
// Reset (and any write of slots_in_use) clears all per-slot flag bits,
// which sit in flip-flops, and reloads the counters; tags need no clearing,
// as they are only ever read behind a set valid bit.
// ============================================================================
module chunk_buffer_pool_pin_policy_unit
    import cbpp_pkg::*;
#(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int CHUNK_ID_BITS = CHUNK_ID_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic [CHUNK_ID_BITS-1:0] chunk_id,
    input  logic [SLOT_IDX_W-1:0]    slot_index,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_IDX_W-1:0]    slot,
    output logic                     must_read,
    output logic                     must_write,
    output logic [CHUNK_ID_BITS-1:0] write_chunk_id
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    // Tag memory: one write port, one registered read port.
    logic [CHUNK_ID_BITS-1:0] tag_mem [NUM_SLOTS];
    logic [CHUNK_ID_BITS-1:0] tag_rd_reg;
    logic [SW-1:0]            tag_raddr;
    logic                     tag_we;
    logic [SW-1:0]            tag_waddr;

    logic [NUM_SLOTS-1:0] valid_reg, pinned_reg, loaded_reg, dirty_reg;
    logic [NUM_SLOTS-1:0] valid_next, pinned_next, loaded_next, dirty_next;
    logic [CFG_W-1:0]     cfg_reg, cfg_next;
    logic [SW-1:0]        last_reg, last_next;
    logic [CW-1:0]        free_reg, free_next, empty_reg, empty_next;
    state_t               state_reg, state_next;
    logic [OP_W-1:0]          op_reg;
    logic [CHUNK_ID_BITS-1:0] op_id_reg;
    logic [SW-1:0]            want_reg;
    logic                     want_hi_reg;
    logic [CW-1:0]            idx_reg, idx_next;   // walk counter
    logic [SW-1:0]            pos_reg, pos_next;   // slot read last cycle
    logic                     rd_pend_reg, rd_pend_next;
    logic                     hit_reg, hit_next;
    logic [SW-1:0]            hit_slot_reg, hit_slot_next;
    logic                     pick_reg, pick_next;
    logic [SW-1:0]            pick_slot_reg, pick_slot_next;
    logic                     ov_reg, ov_next;
    logic [STATUS_W-1:0]      st_reg, st_next;
    logic [SW-1:0]            sl_reg, sl_next;
    logic                     mr_reg, mr_next, mw_reg, mw_next;
    logic [CHUNK_ID_BITS-1:0] wid_reg, wid_next;

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= op_id_reg;
        end
        tag_rd_reg <= tag_mem[tag_raddr];
    end

    // Active slot count, clamped to one..NUM_SLOTS.
    logic [CW-1:0] n_act;
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_act = CW'(1);
        end
        else if (32'(cfg_reg) > NUM_SLOTS)
        begin
            n_act = CW'(NUM_SLOTS);
        end
        else
        begin
            n_act = CW'(cfg_reg);
        end
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && !paddr;
    assign pready = 1'b1;
    assign prdata = {{(32-CFG_W){1'b0}}, cfg_reg};

    logic in_acc, res_free;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign res_free = !ov_reg || !out_stall;

    // Next slot after p, wrapping at n_act.
    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] p, input logic [CW-1:0] n);
        logic [CW:0] t;
        t = (CW+1)'(p) + 1'b1;
        if (t >= (CW+1)'(n))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = t[SW-1:0];
        end
    endfunction

    logic [SW-1:0] tgt;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg; pinned_next = pinned_reg;
        loaded_next = loaded_reg; dirty_next = dirty_reg;
        cfg_next = cfg_reg; last_next = last_reg;
        free_next = free_reg; empty_next = empty_reg;
        idx_next = idx_reg; pos_next = pos_reg; rd_pend_next = 1'b0;
        hit_next = hit_reg; hit_slot_next = hit_slot_reg;
        pick_next = pick_reg; pick_slot_next = pick_slot_reg;
        ov_next = ov_reg && out_stall;
        st_next = st_reg; sl_next = sl_reg; mr_next = mr_reg; mw_next = mw_reg;
        wid_next = wid_reg;
        tag_raddr = pos_reg; tag_we = 1'b0; tag_waddr = '0; tgt = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_LOOK;
                    idx_next = '0; pos_next = '0; hit_next = 1'b0;
                    pick_next = 1'b0;
                end
            end
            S_LOOK:
            begin
                // Issue a read per slot; check the slot read last cycle.
                if (rd_pend_reg && !hit_reg && valid_reg[pos_reg]
                    && tag_rd_reg == op_id_reg)
                begin
                    hit_next = 1'b1; hit_slot_next = pos_reg;
                end
                if (idx_reg < n_act)
                begin
                    tag_raddr = idx_reg[SW-1:0];
                    pos_next = idx_reg[SW-1:0];
                    rd_pend_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    // The last pinned slot is always below the active count.
                    idx_next = '0;
                    pos_next = nxt(last_reg, n_act);
                    if (op_reg == OP_PIN_AT)
                    begin
                        tag_raddr = want_reg;   // victim tag for a pin at slot
                    end
                    state_next = (op_reg == OP_PIN && !hit_next && free_reg != '0)
                                 ? S_SCAN : S_DECIDE;
                end
            end
            S_SCAN:
            begin
                tag_raddr = pos_reg;
                if (!pick_reg && idx_reg < n_act)
                begin
                    if ((empty_reg != '0) ? !valid_reg[pos_reg] : !pinned_reg[pos_reg])
                    begin
                        pick_next = 1'b1; pick_slot_next = pos_reg;
                    end
                    else
                    begin
                        pos_next = nxt(pos_reg, n_act);
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    rd_pend_next = 1'b1;   // victim tag read issued
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // Keep the victim tag on the read port while the result waits.
                tgt = (op_reg == OP_PIN_AT) ? want_reg : pick_slot_reg;
                tag_raddr = tgt;
                if (res_free)
                begin
                    st_next = ST_OK; sl_next = '0; mr_next = 1'b0; mw_next = 1'b0;
                    wid_next = '0;
                    if (op_reg == OP_PIN || op_reg == OP_PIN_AT)
                    begin
                        if (op_reg == OP_PIN_AT && (want_hi_reg ||
                            32'(want_reg) >= 32'(n_act) || free_reg == '0))
                        begin
                            st_next = ST_NOFREE;
                        end
                        else if (op_reg == OP_PIN && free_reg == '0)
                        begin
                            st_next = ST_NOFREE;
                        end
                        else if (op_reg == OP_PIN && hit_reg)
                        begin
                            sl_next = hit_slot_reg;
                            if (pinned_reg[hit_slot_reg])
                            begin
                                st_next = ST_PINNED;
                            end
                            else
                            begin
                                pinned_next[hit_slot_reg] = 1'b1;
                                loaded_next[hit_slot_reg] = 1'b1;
                                free_next = free_reg - 1'b1;
                            end
                        end
                        else if (op_reg == OP_PIN && !pick_reg)
                        begin
                            st_next = ST_NOFREE;
                        end
                        else if (op_reg == OP_PIN_AT && pinned_reg[want_reg])
                        begin
                            st_next = ST_PINNED; sl_next = want_reg;
                        end
                        else
                        begin
                            // Claim: victim tag arrived from the memory read.
                            if (!valid_reg[tgt])
                            begin
                                if (empty_reg != '0)
                                begin
                                    empty_next = empty_reg - 1'b1;
                                end
                            end
                            else if (dirty_reg[tgt])
                            begin
                                mw_next = 1'b1; wid_next = tag_rd_reg;
                            end
                            free_next = free_reg - 1'b1;
                            last_next = tgt;
                            tag_we = 1'b1; tag_waddr = tgt;
                            valid_next[tgt] = 1'b1; pinned_next[tgt] = 1'b1;
                            loaded_next[tgt] = 1'b0; dirty_next[tgt] = 1'b0;
                            sl_next = tgt; mr_next = 1'b1;
                        end
                    end
                    else if (op_reg <= OP_FLUSH)
                    begin
                        if (!hit_reg)
                        begin
                            st_next = ST_NOTRES;
                        end
                        else
                        begin
                            sl_next = hit_slot_reg;
                            unique case (op_reg)
                                OP_UNPIN:
                                begin
                                    if (!pinned_reg[hit_slot_reg])
                                    begin
                                        st_next = ST_NOTPIN;
                                    end
                                    else
                                    begin
                                        pinned_next[hit_slot_reg] = 1'b0;
                                        free_next = free_reg + 1'b1;
                                    end
                                end
                                OP_LOAD:
                                begin
                                    if (!loaded_reg[hit_slot_reg])
                                    begin
                                        mr_next = 1'b1;
                                        loaded_next[hit_slot_reg] = 1'b1;
                                    end
                                end
                                OP_DIRTY:
                                begin
                                    dirty_next[hit_slot_reg] = 1'b1;
                                end
                                default:
                                begin
                                    if (!pinned_reg[hit_slot_reg])
                                    begin
                                        st_next = ST_NOTPIN;
                                    end
                                    else if (dirty_reg[hit_slot_reg])
                                    begin
                                        mw_next = 1'b1; wid_next = op_id_reg;
                                        dirty_next[hit_slot_reg] = 1'b0;
                                    end
                                end
                            endcase
                        end
                    end
                    ov_next = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            cfg_next = pwdata[CFG_W-1:0];
            valid_next = '0; pinned_next = '0; loaded_next = '0; dirty_next = '0;
            last_next = '0;
            if (pwdata[CFG_W-1:0] == '0)
            begin
                free_next = CW'(1);
            end
            else if (32'(pwdata[CFG_W-1:0]) > NUM_SLOTS)
            begin
                free_next = CW'(NUM_SLOTS);
            end
            else
            begin
                free_next = CW'(pwdata[CFG_W-1:0]);
            end
            empty_next = free_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0; pinned_reg <= '0; loaded_reg <= '0; dirty_reg <= '0;
            cfg_reg <= CFG_RESET; last_reg <= '0;
            free_reg <= (NUM_SLOTS < 16) ? CW'(NUM_SLOTS) : CW'(16);
            empty_reg <= (NUM_SLOTS < 16) ? CW'(NUM_SLOTS) : CW'(16);
            ov_reg <= 1'b0; rd_pend_reg <= 1'b0;
            hit_reg <= 1'b0; pick_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next; pinned_reg <= pinned_next;
            loaded_reg <= loaded_next; dirty_reg <= dirty_next;
            cfg_reg <= cfg_next; last_reg <= last_next;
            free_reg <= free_next; empty_reg <= empty_next;
            ov_reg <= ov_next; rd_pend_reg <= rd_pend_next;
            hit_reg <= hit_next; pick_reg <= pick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg <= operation; op_id_reg <= chunk_id;
            want_reg <= SW'(slot_index);
            want_hi_reg <= (32'(slot_index) >= NUM_SLOTS);
        end
        idx_reg <= idx_next; pos_reg <= pos_next;
        hit_slot_reg <= hit_slot_next; pick_slot_reg <= pick_slot_next;
        st_reg <= st_next; sl_reg <= sl_next; mr_reg <= mr_next; mw_reg <= mw_next;
        wid_reg <= wid_next;
    end

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign slot           = SLOT_IDX_W'(sl_reg);
    assign must_read      = mr_reg;
    assign must_write     = mw_reg;
    assign write_chunk_id = wid_reg;

endmodule

@@ tb/tb_top.sv @@
// ============================================================================
// tb_top: self-checking bench for the buffer pool slot table
// Directed requests from a table, then constrained-free random phases over
// several slots_in_use settings, checked against an in-bench slot model.
// ============================================================================
module tb_top;
    import cbpp_pkg::*;

    // Result of one request, laid out as the output ports are.
    typedef struct packed {
        logic [STATUS_W-1:0]   st;
        logic [SLOT_IDX_W-1:0] sl;
        logic                  rd;
        logic                  wr;
        logic [15:0]           wid;
    } slot_result_t;

    // One row of the directed table. Where has_exp is set the expected
    // result is written out by hand; otherwise the slot model supplies it.
    typedef struct {
        logic [OP_W-1:0]       op;
        logic [15:0]           id;
        logic [SLOT_IDX_W-1:0] idx;
        bit                    has_exp;
        slot_result_t          exp;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic                  paddr = 1'b0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation = OP_PIN;
    logic [15:0]           chunk_id = '0;
    logic [SLOT_IDX_W-1:0] slot_index = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  must_read;
    logic                  must_write;
    logic [15:0]           write_chunk_id;

    chunk_buffer_pool_pin_policy_unit dut (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Slot model: a private copy of the table and counters.
    // ------------------------------------------------------------------------
    logic [15:0] m_tag [16];
    bit   [15:0] m_valid, m_pinned, m_loaded, m_dirty;
    int          m_last, m_free, m_empty, m_active;

    slot_result_t pending_results[$];
    int errors = 0;
    int n_requests = 0, n_results = 0, n_writebacks = 0, n_nofree = 0;

    // A write of slots_in_use clears the whole table; zero behaves as one
    // slot and anything above sixteen as sixteen.
    function automatic void table_reinit(int unsigned v);
        m_active = (v == 0) ? 1 : (v > 16) ? 16 : v;
        m_valid = '0; m_pinned = '0; m_loaded = '0; m_dirty = '0;
        m_last = 0;
        m_free = m_active;
        m_empty = m_active;
    endfunction

    function automatic int lookup(logic [15:0] id);
        for (int i = 0; i < m_active; i++)
            if (m_valid[i] && m_tag[i] == id) return i;
        return -1;
    endfunction

    function automatic void claim_slot(int s, logic [15:0] id, ref slot_result_t r);
        if (!m_valid[s]) begin
            if (m_empty > 0) m_empty--;
        end
        else if (m_dirty[s]) begin
            r.wr = 1'b1;
            r.wid = m_tag[s];
        end
        if (m_free > 0) m_free--;
        m_last = s;
        m_tag[s] = id;
        m_valid[s] = 1'b1;
        m_pinned[s] = 1'b1;
        m_loaded[s] = 1'b0;
        m_dirty[s] = 1'b0;
        r.sl = SLOT_IDX_W'(s);
        r.rd = 1'b1;
    endfunction

    function automatic slot_result_t slot_predict(logic [OP_W-1:0] op, logic [15:0] id,
                                                  logic [SLOT_IDX_W-1:0] idx);
        slot_result_t r;
        int f, pick, s;
        r = '0;
        f = lookup(id);
        pick = -1;
        if (op == OP_PIN) begin
            if (m_free == 0) r.st = ST_NOFREE;
            else if (f >= 0) begin
                r.sl = SLOT_IDX_W'(f);
                if (m_pinned[f]) r.st = ST_PINNED;
                else begin
                    m_pinned[f] = 1'b1;
                    m_loaded[f] = 1'b1;
                    m_free--;
                end
            end
            else begin
                for (int i = 0; i < m_active && pick < 0; i++) begin
                    s = (i + (m_last % m_active) + 1) % m_active;
                    if (m_empty > 0 ? !m_valid[s] : !m_pinned[s]) pick = s;
                end
                if (pick < 0) r.st = ST_NOFREE;
                else claim_slot(pick, id, r);
            end
        end
        else if (op == OP_PIN_AT) begin
            if (idx >= m_active || m_free == 0) r.st = ST_NOFREE;
            else if (m_pinned[idx]) begin
                r.st = ST_PINNED;
                r.sl = idx;
            end
            else claim_slot(idx, id, r);
        end
        else if (op <= OP_FLUSH) begin
            if (f < 0) r.st = ST_NOTRES;
            else begin
                r.sl = SLOT_IDX_W'(f);
                case (op)
                    OP_UNPIN:
                        if (!m_pinned[f]) r.st = ST_NOTPIN;
                        else begin
                            m_pinned[f] = 1'b0;
                            m_free++;
                        end
                    OP_LOAD:
                        if (!m_loaded[f]) begin
                            r.rd = 1'b1;
                            m_loaded[f] = 1'b1;
                        end
                    OP_DIRTY:
                        m_dirty[f] = 1'b1;
                    default:
                        if (!m_pinned[f]) r.st = ST_NOTPIN;
                        else if (m_dirty[f]) begin
                            r.wr = 1'b1;
                            r.wid = id;
                            m_dirty[f] = 1'b0;
                        end
                endcase
            end
        end
        return r;
    endfunction

    task automatic report(string what, slot_result_t got, slot_result_t exp);
        errors++;
        $display("MISMATCH %s: got st=%0d sl=%0d rd=%0b wr=%0b wid=%h, %s%0d sl=%0d rd=%0b wr=%0b wid=%h",
                 what, got.st, got.sl, got.rd, got.wr, got.wid, "exp st=",
                 exp.st, exp.sl, exp.rd, exp.wr, exp.wid);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: compares every accepted result with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        slot_result_t got, exp;
        got = '{status, slot, must_read, must_write, write_chunk_id};
        if (rst_n && out_valid && !out_stall) begin
            n_results++;
            if (pending_results.size() == 0) report("unexpected result", got, got);
            else begin
                exp = pending_results.pop_front();
                if (got.st !== exp.st) report("status", got, exp);
                else if (got.sl !== exp.sl) report("slot", got, exp);
                else if (got.rd !== exp.rd) report("must_read", got, exp);
                else if (got.wr !== exp.wr) report("must_write", got, exp);
                else if (got.wid !== exp.wid) report("write_chunk_id", got, exp);
                if (exp.wr) n_writebacks++;
                if (exp.st == ST_NOFREE) n_nofree++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random stretches of stall and flow, plus a long hold
    // on demand so that the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    bit want_long_hold = 0;
    int hold_left = 0, seg_left = 0;
    bit seg_stall = 0;

    always @(posedge clk) begin
        if (want_long_hold) begin
            want_long_hold = 0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            if (seg_left == 0) begin
                seg_stall = ($urandom_range(0, 99) < 35);
                seg_left = ($urandom_range(0, 99) < 8) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 4);
            end
            seg_left--;
            out_stall <= seg_stall;
        end
    end

    // Watchdog: any cycle with no request or result taken counts towards the
    // limit, which is well beyond the longest legitimate quiet spell.
    int quiet = 0;
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
        else quiet++;
        if (quiet >= 5000) begin
            $display("timeout after %0d idle cycles", quiet);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one request and waits until the block takes it. The model is
    // advanced at the moment of acceptance.
    task automatic send_request(logic [OP_W-1:0] op, logic [15:0] id,
                                logic [SLOT_IDX_W-1:0] idx, bit has_exp,
                                slot_result_t exp);
        slot_result_t pred;
        int g;
        in_valid <= 1'b1;
        operation <= op;
        chunk_id <= id;
        slot_index <= idx;
        do @(posedge clk); while (in_stall);
        pred = slot_predict(op, id, idx);
        pending_results.push_back(has_exp ? exp : pred);
        n_requests++;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle; the model follows it.
    task automatic write_slots_in_use(logic [CFG_W-1:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= 1'b0;
        pwdata <= {27'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        table_reinit(v);
        @(posedge clk);
    endtask

    dir_row_t dir_rows[$];

    function automatic void add_row(logic [OP_W-1:0] op, logic [15:0] id,
                                    logic [SLOT_IDX_W-1:0] idx, bit has_exp,
                                    slot_result_t exp);
        dir_row_t row;
        row.op = op; row.id = id; row.idx = idx;
        row.has_exp = has_exp; row.exp = exp;
        dir_rows.push_back(row);
    endfunction

    initial begin
        logic [15:0] id_pool [20];
        logic [CFG_W-1:0] settings [8];
        logic [OP_W-1:0] op;
        logic [15:0] id;
        int r, pool_n;

        settings = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd5, 5'd16, 5'd3, 5'd8};
        table_reinit(CFG_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset setting of sixteen slots. The first pin
        // scans from the slot after slot 0, so lands in slot 1.
        add_row(OP_UNPIN,  16'h1234, 4'd0, 1, '{ST_NOTRES, 4'd0, 1'b0, 1'b0, 16'h0});
        add_row(OP_LOAD,   16'h1234, 4'd0, 1, '{ST_NOTRES, 4'd0, 1'b0, 1'b0, 16'h0});
        add_row(OP_FLUSH,  16'h1234, 4'd0, 1, '{ST_NOTRES, 4'd0, 1'b0, 1'b0, 16'h0});
        add_row(OP_PIN,    16'h0000, 4'd0, 1, '{ST_OK,     4'd1, 1'b1, 1'b0, 16'h0});
        add_row(OP_PIN,    16'h0000, 4'd0, 1, '{ST_PINNED, 4'd1, 1'b0, 1'b0, 16'h0});
        add_row(OP_LOAD,   16'h0000, 4'd0, 0, '0);
        add_row(OP_LOAD,   16'h0000, 4'd0, 0, '0);
        add_row(OP_DIRTY,  16'h0000, 4'd0, 0, '0);
        add_row(OP_FLUSH,  16'h0000, 4'd0, 1, '{ST_OK,     4'd1, 1'b0, 1'b1, 16'h0000});
        add_row(OP_PIN,    16'hFFFF, 4'd9, 0, '0);
        add_row(OP_DIRTY,  16'hFFFF, 4'd0, 0, '0);
        add_row(OP_UNPIN,  16'hFFFF, 4'd0, 0, '0);
        add_row(OP_UNPIN,  16'hFFFF, 4'd0, 0, '0);
        add_row(OP_FLUSH,  16'hFFFF, 4'd0, 0, '0);
        add_row(OP_PIN,    16'hFFFF, 4'd0, 0, '0);
        add_row(OP_PIN_AT, 16'hABCD, 4'd15, 0, '0);
        add_row(OP_PIN_AT, 16'h5555, 4'd1, 1, '{ST_PINNED, 4'd1, 1'b0, 1'b0, 16'h0});
        add_row(OP_PIN_AT, 16'hAAAA, 4'd0, 0, '0);
        add_row(OP_DIRTY,  16'hAAAA, 4'd0, 0, '0);
        add_row(OP_UNPIN,  16'hAAAA, 4'd0, 0, '0);
        add_row(OP_PIN_AT, 16'h0F0F, 4'd0, 0, '0);
        add_row(3'd6,      16'h0000, 4'd0, 1, '{ST_OK, 4'd0, 1'b0, 1'b0, 16'h0});
        add_row(3'd7,      16'hFFFF, 4'd15, 1, '{ST_OK, 4'd0, 1'b0, 1'b0, 16'h0});
        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].id, dir_rows[i].idx,
                         dir_rows[i].has_exp, dir_rows[i].exp);
        wait_drained();

        // Random phases. Each setting gets a small pool of chunk ids a little
        // larger than the table, so that hits, evictions of dirty victims and
        // a full table all come up often.
        foreach (settings[p]) begin
            write_slots_in_use(settings[p]);
            pool_n = m_active + 4;
            for (int k = 0; k < pool_n; k++) id_pool[k] = 16'($urandom_range(0, 65535));
            for (int k = 0; k < 142; k++) begin
                r = $urandom_range(0, 99);
                op = (r < 30) ? OP_PIN : (r < 40) ? OP_PIN_AT : (r < 58) ? OP_UNPIN :
                     (r < 68) ? OP_LOAD : (r < 80) ? OP_DIRTY : (r < 96) ? OP_FLUSH :
                     OP_W'($urandom_range(6, 7));
                id = ($urandom_range(0, 99) < 88) ? id_pool[$urandom_range(0, pool_n - 1)]
                                                  : 16'($urandom_range(0, 65535));
                // Hold the receiver off for a long spell while requests keep
                // coming, so the block fills up and stalls its input.
                if (p == 2 && k == 40) want_long_hold = 1;
                // Let the block drain completely once in mid-phase.
                if (p == 4 && k == 70) begin
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge clk);
                end
                send_request(op, id, SLOT_IDX_W'($urandom_range(0, 15)), 0, '0);
            end
            wait_drained();
        end

        $display("Covered %0d requests and %0d results over %0d slot settings;",
                 n_requests, n_results, $size(settings) + 1);
        $display("%0d write-backs and %0d no-free-slot results were predicted.",
                 n_writebacks, n_nofree);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ chunk_buffer_pool_pin_policy_unit.f @@
rtl/cbpp_pkg.sv
rtl/chunk_buffer_pool_pin_policy_unit.sv
tb/tb_top.sv
